// ===== rtl/core/hpcc_pkg.sv =====
`default_nettype none

package hpcc_pkg;

   // fixed field widths of the ports
   localparam int KIND_W       = 1;
   localparam int NODE_FIELD_W = 6;
   localparam int DIST_FIELD_W = 16;
   localparam int NCOUNT_W     = 7;
   localparam int WEIGHT_W     = 16;
   localparam int BOUND_W      = 22;
   localparam int FRAC_BITS    = 12;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 22;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_COLLECT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_TRANSFER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_DELIVER  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COVER_BOUND     = 3'd4;

   // register reset values
   localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 16'd4096;
   localparam logic [BOUND_W-1:0]  BOUND_RESET      = 22'd0;

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_NAMED_HEAD = 6'b000010,
      S_NAMED_PAIR = 6'b000100,
      S_SCAN_HEAD  = 6'b001000,
      S_SCAN_PAIR  = 6'b010000,
      S_DRAIN      = 6'b100000
   } state_type;

   // one evaluation token travelling through the cost pipeline
   typedef struct packed {
      logic valid;
      logic head;   // reads origin to first hub only, sets the collect term
      logic named;  // belongs to the named pair, not the scan
      logic ok0;    // port 0 entry inside the table
      logic ok1;    // port 1 entry inside the table
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/core/hub_pair_coverage_check_unit.sv =====
`default_nettype none

// Hub pair coverage check.
// A transaction is accepted when start is high and busy is low. A load
// (req_kind 0) writes req_distance at row req_origin, column req_destination
// of the distance table in the accept cycle and gives no result; busy stays
// low. A query (req_kind 1) raises busy and answers with one result on
// rsp_pair_covers and rsp_any_pair_covers, marked by rsp_strobe for one cycle.
// A query, with the node count saturated at MAX_NODES, issues into one
// cost evaluation pipeline (dual-read table, two multipliers, adder, compare)
// once per cycle: the collect term and the cost of the named pair, then once
// per first hub for the collect term and once per hub pair, then it drains.
// A new transaction may be accepted in the strobe cycle. The receiver cannot
// stall; the result is shown once. Registers are written through csr_wr_en /
// csr_index / csr_wr_data; the user must write them only while idle, the block
// does not enforce it. Reset restores the register defaults and the sequencer;
// the table contents are undefined until loaded and need no clearing.

module hub_pair_coverage_check_unit #(
   parameter int MAX_NODES = 64,
   parameter int DIST_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [hpcc_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [hpcc_pkg::NODE_FIELD_W-1:0]  req_origin,
   input  wire logic [hpcc_pkg::NODE_FIELD_W-1:0]  req_destination,
   input  wire logic [hpcc_pkg::DIST_FIELD_W-1:0]  req_distance,
   input  wire logic [hpcc_pkg::NODE_FIELD_W-1:0]  req_first_hub,
   input  wire logic [hpcc_pkg::NODE_FIELD_W-1:0]  req_second_hub,
   output logic                                    rsp_strobe,
   output logic                                    rsp_pair_covers,
   output logic                                    rsp_any_pair_covers,
   input  wire logic                               csr_wr_en,
   input  wire logic [hpcc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hpcc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   import hpcc_pkg::*;

   localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int ADDR_W    = 2 * NODE_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int PROD_W    = WEIGHT_W + DIST_BITS;
   localparam int SUM_W     = PROD_W + 2;
   localparam int SBOUND_W  = BOUND_W + FRAC_BITS;
   localparam int CMP_W     = (SUM_W > SBOUND_W) ? SUM_W : SBOUND_W;

   // configuration registers
   logic [NCOUNT_W-1:0] node_count_ff;
   logic [WEIGHT_W-1:0] w_collect_ff;
   logic [WEIGHT_W-1:0] w_transfer_ff;
   logic [WEIGHT_W-1:0] w_deliver_ff;
   logic [BOUND_W-1:0]  bound_ff;

   // sequencer
   state_type                 state_ff, state_in;
   logic [NODE_FIELD_W-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in, m_ff, m_in;
   logic [NODE_W-1:0]         a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic                      pair_ff, pair_in, any_ff, any_in;
   logic                      strobe_ff, strobe_in;

   // pipeline
   token_type                 tok0, tok1_ff, tok2_ff, tok3_ff;
   logic [ADDR_W-1:0]         rd0_addr, rd1_addr, wr_addr;
   logic                      wr_en;
   logic [DIST_BITS-1:0]      dist_mem [MEM_DEPTH];
   logic [DIST_BITS-1:0]      rd0_ff, rd1_ff;
   logic [WEIGHT_W-1:0]       w0;
   logic [PROD_W-1:0]         prod0_ff, prod0_in, prod1_ff, prod1_in, collect_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      hit;

   logic                      accept, i_ok, j_ok, k_ok, m_ok, last_b, last_a;
   logic [8:0]                nc_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   assign i_ok = (32'(i_ff) < MAX_NODES);
   assign j_ok = (32'(j_ff) < MAX_NODES);
   assign k_ok = (32'(k_ff) < MAX_NODES);
   assign m_ok = (32'(m_ff) < MAX_NODES);

   assign last_b = ((CNT_W'(b_ff) + CNT_W'(1)) == n_ff);
   assign last_a = ((CNT_W'(a_ff) + CNT_W'(1)) == n_ff);

   // load write port
   assign wr_en   = accept && (req_kind == KIND_LOAD) &&
                    (32'(req_origin) < MAX_NODES) && (32'(req_destination) < MAX_NODES);
   assign wr_addr = {NODE_W'(req_origin), NODE_W'(req_destination)};

   // issue stage: addresses and token for the current sequencer step
   always_comb begin
      tok0     = '0;
      rd0_addr = '0;
      rd1_addr = '0;
      case (state_ff)
         S_NAMED_HEAD: begin
            tok0     = '{valid: 1'b1, head: 1'b1, named: 1'b1, ok0: i_ok && k_ok, ok1: 1'b0};
            rd0_addr = {NODE_W'(i_ff), NODE_W'(k_ff)};
         end
         S_NAMED_PAIR: begin
            tok0     = '{valid: 1'b1, head: 1'b0, named: 1'b1,
                         ok0: k_ok && m_ok, ok1: m_ok && j_ok};
            rd0_addr = {NODE_W'(k_ff), NODE_W'(m_ff)};
            rd1_addr = {NODE_W'(m_ff), NODE_W'(j_ff)};
         end
         S_SCAN_HEAD: begin
            tok0     = '{valid: 1'b1, head: 1'b1, named: 1'b0, ok0: i_ok, ok1: 1'b0};
            rd0_addr = {NODE_W'(i_ff), a_ff};
         end
         S_SCAN_PAIR: begin
            tok0     = '{valid: 1'b1, head: 1'b0, named: 1'b0, ok0: 1'b1, ok1: j_ok};
            rd0_addr = {a_ff, b_ff};
            rd1_addr = {b_ff, NODE_W'(j_ff)};
         end
         default: begin
            tok0 = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= DIST_BITS'(req_distance);
      end
      rd0_ff <= dist_mem[rd0_addr];
      rd1_ff <= dist_mem[rd1_addr];
   end

   // product stage, out-of-table entries read as zero distance
   always_comb begin
      w0       = tok1_ff.head ? w_collect_ff : w_transfer_ff;
      prod0_in = tok1_ff.ok0 ? PROD_W'(w0) * PROD_W'(rd0_ff) : '0;
      prod1_in = tok1_ff.ok1 ? PROD_W'(w_deliver_ff) * PROD_W'(rd1_ff) : '0;
   end

   // sum stage, collect term comes from the last head token ahead in order
   assign sum_in = SUM_W'(prod0_ff) + SUM_W'(prod1_ff) + SUM_W'(collect_ff);
   assign hit    = (CMP_W'(sum_ff) <= CMP_W'({bound_ff, {FRAC_BITS{1'b0}}}));

   always_ff @(posedge clock) begin
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      sum_ff   <= sum_in;
      if (tok2_ff.valid && tok2_ff.head) begin
         collect_ff <= prod0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         tok3_ff <= '0;
      end else begin
         tok1_ff <= tok0;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok2_ff.head ? '0 : tok2_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      n_in      = n_ff;
      pair_in   = pair_ff;
      any_in    = any_ff;
      strobe_in = 1'b0;
      nc_wide   = 9'(node_count_ff);

      if (tok3_ff.valid) begin
         if (tok3_ff.named) begin
            pair_in = hit;
         end else begin
            any_in = any_ff | hit;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind == KIND_QUERY)) begin
               i_in     = req_origin;
               j_in     = req_destination;
               k_in     = req_first_hub;
               m_in     = req_second_hub;
               a_in     = '0;
               b_in     = '0;
               n_in     = (32'(nc_wide) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(nc_wide);
               any_in   = 1'b0;
               state_in = S_NAMED_HEAD;
            end
         end
         S_NAMED_HEAD: begin
            state_in = S_NAMED_PAIR;
         end
         S_NAMED_PAIR: begin
            state_in = (n_ff == '0) ? S_DRAIN : S_SCAN_HEAD;
         end
         S_SCAN_HEAD: begin
            b_in     = '0;
            state_in = S_SCAN_PAIR;
         end
         S_SCAN_PAIR: begin
            if (last_b) begin
               if (last_a) begin
                  state_in = S_DRAIN;
               end else begin
                  a_in     = a_ff + NODE_W'(1);
                  state_in = S_SCAN_HEAD;
               end
            end else begin
               b_in = b_ff + NODE_W'(1);
            end
         end
         S_DRAIN: begin
            if (!tok1_ff.valid && !tok2_ff.valid && !tok3_ff.valid) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      m_ff    <= m_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      pair_ff <= pair_in;
      any_ff  <= any_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         w_collect_ff  <= WEIGHT_RESET;
         w_transfer_ff <= WEIGHT_RESET;
         w_deliver_ff  <= WEIGHT_RESET;
         bound_ff      <= BOUND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NODE_COUNT:      node_count_ff <= csr_wr_data[NCOUNT_W-1:0];
            CSR_WEIGHT_COLLECT:  w_collect_ff  <= csr_wr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_TRANSFER: w_transfer_ff <= csr_wr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_DELIVER:  w_deliver_ff  <= csr_wr_data[WEIGHT_W-1:0];
            CSR_COVER_BOUND:     bound_ff      <= csr_wr_data[BOUND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_pair_covers     = pair_ff;
   assign rsp_any_pair_covers = any_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a query is still running");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_QUERY)) |=> busy)
      else $error("query accepted without raising busy");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(tok1_ff.valid || tok2_ff.valid || tok3_ff.valid))
      else $error("cost pipeline not empty while idle");
`endif

endmodule

`default_nettype wire
